// ===== rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// shared types and constants of the throttle step sequencer
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int unsigned MaxSteps = 16;
    localparam int unsigned StepW    = $clog2(MaxSteps);
    localparam int unsigned CountW   = $clog2(MaxSteps + 1);
    localparam int unsigned PctW     = 10;
    localparam int unsigned MsW      = 24;
    localparam int unsigned RampW    = 16;
    localparam int unsigned StepCfgW = 8;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 24;

    localparam logic [PctW-1:0]     PctMax    = PctW'(1000);
    localparam logic [MsW-1:0]      MsMax     = {MsW{1'b1}};
    localparam logic [StepCfgW-1:0] StepLimit = StepCfgW'(MaxSteps);

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_START = 2'd2,
        REQ_STOP  = 2'd3
    } t_req;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_COMMON_STEP = 2'd0,
        CFG_RAMP        = 2'd1,
        CFG_PER_STEP    = 2'd2,
        CFG_STEP_COUNT  = 2'd3
    } t_cfg_idx;

endpackage

// ===== rtl/throttle_step_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// throttle_step_sequencer_top
// input reg at accept, then result reg; state updates as an item enters the result reg
// throughput: one item per cycle while the output side is not stalling
// reset: synchronous active-low reset clears control state and config registers
// step tables are not reset and hold garbage until loaded
// ----------------------------------------------------------------------------
module throttle_step_sequencer_top
    import tss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_req_type,
    input  logic [3:0]          i_entry_index,
    input  logic [PctW-1:0]     i_entry_pct,
    input  logic [MsW-1:0]      i_entry_time_ms,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [PctW-1:0]     o_target_pct,
    output logic                o_target_valid,
    output logic                o_steady,
    output logic [3:0]          o_step_index,
    output logic                o_running,
    output logic                o_finished
);

    logic [MsW-1:0]      r_common_step_ms;
    logic [RampW-1:0]    r_ramp_ms;
    logic                r_per_step_en;
    logic [StepCfgW-1:0] r_step_count;

    logic [PctW-1:0] r_pct_table  [MaxSteps];
    logic [MsW-1:0]  r_time_table [MaxSteps];

    logic              r_active, n_active;
    logic [StepW-1:0]  r_cur_step, n_cur_step;
    logic [MsW-1:0]    r_elapsed, n_elapsed;
    logic              r_steady, n_steady;
    logic [CountW-1:0] r_act_count, n_act_count;

    logic            r_in_valid;
    t_req            r_req;
    logic [3:0]      r_idx;
    logic [PctW-1:0] r_pct;
    logic [MsW-1:0]  r_time;

    logic            r_out_valid;
    logic [PctW-1:0] r_tgt, n_tgt;
    logic            r_tvalid, n_tvalid;
    logic [3:0]      r_shown, n_shown;
    logic            r_fin, n_fin;

    logic              advance;
    logic              load_en;
    logic [MsW-1:0]    inc_elapsed;
    logic [MsW-1:0]    dur;
    logic [CountW-1:0] next_step;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign load_en    = advance && (r_req == REQ_LOAD) && ({1'b0, r_idx} < 5'(MaxSteps));

    assign inc_elapsed = (r_elapsed < MsMax) ? r_elapsed + MsW'(1) : r_elapsed;
    assign dur         = r_per_step_en ? r_time_table[r_cur_step] : r_common_step_ms;
    assign next_step   = CountW'(r_cur_step) + CountW'(1);

    always_comb begin
        n_active    = r_active;
        n_cur_step  = r_cur_step;
        n_elapsed   = r_elapsed;
        n_steady    = r_steady;
        n_act_count = r_act_count;
        n_tgt       = '0;
        n_tvalid    = 1'b0;
        n_fin       = 1'b0;
        n_shown     = 4'(r_cur_step);
        case (r_req)
            REQ_TICK: begin
                if (r_active) begin
                    n_elapsed = inc_elapsed;
                    n_steady  = (inc_elapsed >= MsW'(r_ramp_ms));
                    n_tgt     = r_pct_table[r_cur_step];
                    n_tvalid  = 1'b1;
                    if (inc_elapsed >= dur) begin
                        if (next_step >= r_act_count) begin
                            n_active   = 1'b0;
                            n_cur_step = '0;
                            n_tgt      = '0;
                            n_fin      = 1'b1;
                            n_shown    = '0;
                        end else begin
                            n_cur_step = next_step[StepW-1:0];
                            n_elapsed  = '0;
                        end
                    end
                end
            end
            REQ_LOAD: begin
            end
            REQ_START: begin
                n_act_count = (r_step_count > StepLimit) ? CountW'(MaxSteps)
                                                          : r_step_count[CountW-1:0];
                n_active    = (n_act_count != '0);
                n_cur_step  = '0;
                n_elapsed   = '0;
                n_steady    = 1'b0;
                n_shown     = '0;
            end
            REQ_STOP: begin
                n_active   = 1'b0;
                n_cur_step = '0;
                n_shown    = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_common_step_ms <= '0;
            r_ramp_ms        <= '0;
            r_per_step_en    <= 1'b0;
            r_step_count     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COMMON_STEP: r_common_step_ms <= i_cfg_data[MsW-1:0];
                CFG_RAMP:        r_ramp_ms        <= i_cfg_data[RampW-1:0];
                CFG_PER_STEP:    r_per_step_en    <= i_cfg_data[0];
                CFG_STEP_COUNT:  r_step_count     <= i_cfg_data[StepCfgW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_pct_table[r_idx[StepW-1:0]]  <= (r_pct > PctMax) ? PctMax : r_pct;
            r_time_table[r_idx[StepW-1:0]] <= r_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_cur_step  <= '0;
            r_elapsed   <= '0;
            r_steady    <= 1'b0;
            r_act_count <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_active    <= n_active;
                r_cur_step  <= n_cur_step;
                r_elapsed   <= n_elapsed;
                r_steady    <= n_steady;
                r_act_count <= n_act_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req  <= t_req'(i_req_type);
            r_idx  <= i_entry_index;
            r_pct  <= i_entry_pct;
            r_time <= i_entry_time_ms;
        end
        if (advance) begin
            r_tgt    <= n_tgt;
            r_tvalid <= n_tvalid;
            r_shown  <= n_shown;
            r_fin    <= n_fin;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_target_pct   = r_tgt;
    assign o_target_valid = r_tvalid;
    assign o_steady       = r_steady;
    assign o_step_index   = r_shown;
    assign o_running      = r_active;
    assign o_finished     = r_fin;

endmodule

// ===== rtl/tss_chk.sv =====
// ----------------------------------------------------------------------------
// tss_chk
// port-level checks of the throttle step sequencer result channel
// ----------------------------------------------------------------------------
module tss_chk
    import tss_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [PctW-1:0] o_target_pct,
    input logic            o_target_valid,
    input logic [3:0]      o_step_index,
    input logic            o_running,
    input logic            o_finished
);

    // finishing tick ends the profile and commands zero
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |->
            o_target_valid && !o_running && o_target_pct == '0 && o_step_index == '0)
        else $error("finish item inconsistent");

    // no throttle command means zero target and no finish
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_target_valid |-> o_target_pct == '0 && !o_finished)
        else $error("target without command");

    // a non-finishing tick keeps the profile running
    a_tick_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target_valid && !o_finished |->
            o_running && o_target_pct <= PctMax)
        else $error("tick item inconsistent");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_target_pct) && $stable(o_step_index)
            && $stable(o_finished))
        else $error("stalled item changed");

endmodule

bind throttle_step_sequencer_top tss_chk u_tss_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_target_pct   (o_target_pct),
    .o_target_valid (o_target_valid),
    .o_step_index   (o_step_index),
    .o_running      (o_running),
    .o_finished     (o_finished)
);

// ===== bench/tb_throttle_step_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tb_throttle_step_sequencer_top
// self-checking bench for the throttle step sequencer: a scoreboard class keeps
// its own copy of the step table, profile state and registers, predicts the
// result of every accepted request and compares it field by field with what
// the block returns, under random gaps and stalls on both handshakes
// ----------------------------------------------------------------------------
module tb_throttle_step_sequencer_top
    import tss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HoldCycles = 50;
    localparam int unsigned QuietLimit = 2000;
    localparam int unsigned PhaseItems = 85;
    localparam int unsigned NumPhases  = 8;

    typedef struct packed {
        logic [PctW-1:0] target_pct;
        logic            target_valid;
        logic            steady;
        logic [3:0]      step_index;
        logic            running;
        logic            finished;
    } t_step_result;

    class throttle_scoreboard;
        logic [PctW-1:0]     pct_tab [MaxSteps];
        logic [MsW-1:0]      time_tab [MaxSteps];
        logic [MsW-1:0]      common_ms;
        logic [RampW-1:0]    ramp;
        logic                per_step;
        logic [StepCfgW-1:0] count_cfg;
        logic                running_q;
        logic [CountW-1:0]   step_q;
        logic [CountW-1:0]   last_step;
        logic [MsW-1:0]      elapsed;
        logic                steady_q;
        t_step_result        expected_q [$];
        int unsigned         errors;
        int unsigned         requests;
        int unsigned         starts;
        int unsigned         finishes;
        int unsigned         driven_ticks;

        function new();
            common_ms = '0;
            ramp = '0;
            per_step = 1'b0;
            count_cfg = '0;
            running_q = 1'b0;
            step_q = '0;
            last_step = '0;
            elapsed = '0;
            steady_q = 1'b0;
            errors = 0;
            requests = 0;
            starts = 0;
            finishes = 0;
            driven_ticks = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void set_config(t_cfg_idx idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_COMMON_STEP: common_ms = data[MsW-1:0];
                CFG_RAMP:        ramp = data[RampW-1:0];
                CFG_PER_STEP:    per_step = data[0];
                CFG_STEP_COUNT:  count_cfg = data[StepCfgW-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(t_req req, logic [3:0] idx, logic [PctW-1:0] pct,
                                   logic [MsW-1:0] ms);
            t_step_result r;
            logic [MsW-1:0] dur;
            r = '0;
            r.step_index = step_q[3:0];
            requests++;
            case (req)
                REQ_TICK: begin
                    if (running_q) begin
                        if (elapsed != MsMax) elapsed = elapsed + 1'b1;
                        dur = per_step ? time_tab[step_q[StepW-1:0]] : common_ms;
                        steady_q = (elapsed >= MsW'(ramp));
                        r.target_pct = pct_tab[step_q[StepW-1:0]];
                        r.target_valid = 1'b1;
                        driven_ticks++;
                        if (elapsed >= dur) begin
                            step_q = step_q + 1'b1;
                            if (step_q >= last_step) begin
                                running_q = 1'b0;
                                step_q = '0;
                                r.target_pct = '0;
                                r.finished = 1'b1;
                                r.step_index = '0;
                                finishes++;
                            end else begin
                                elapsed = '0;
                            end
                        end
                    end
                end
                REQ_LOAD: begin
                    pct_tab[idx] = (pct > PctMax) ? PctMax : pct;
                    time_tab[idx] = ms;
                end
                REQ_START: begin
                    last_step = (count_cfg > StepLimit) ? CountW'(MaxSteps)
                                                        : count_cfg[CountW-1:0];
                    running_q = (last_step != 0);
                    step_q = '0;
                    elapsed = '0;
                    steady_q = 1'b0;
                    r.step_index = '0;
                    starts++;
                end
                default: begin
                    running_q = 1'b0;
                    step_q = '0;
                    r.step_index = '0;
                end
            endcase
            r.steady = steady_q;
            r.running = running_q;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
                         exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_step_result got);
            t_step_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("target_pct", want.target_pct, got.target_pct);
            compare_field("target_valid", want.target_valid, got.target_valid);
            compare_field("steady", want.steady, got.steady);
            compare_field("step_index", want.step_index, got.step_index);
            compare_field("running", want.running, got.running);
            compare_field("finished", want.finished, got.finished);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_req_type = '0;
    logic [3:0]          i_entry_index = '0;
    logic [PctW-1:0]     i_entry_pct = '0;
    logic [MsW-1:0]      i_entry_time_ms = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [PctW-1:0]     o_target_pct;
    logic                o_target_valid;
    logic                o_steady;
    logic [3:0]          o_step_index;
    logic                o_running;
    logic                o_finished;

    throttle_scoreboard  sb = new();
    logic [MaxSteps-1:0] loaded_mask = '0;
    bit                  tx_calm = 1'b0;
    bit                  rx_calm = 1'b0;
    bit                  rx_hold_req = 1'b0;
    int unsigned         settings_applied = 0;

    throttle_step_sequencer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_entry_pct     (i_entry_pct),
        .i_entry_time_ms (i_entry_time_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_target_pct    (o_target_pct),
        .o_target_valid  (o_target_valid),
        .o_steady        (o_steady),
        .o_step_index    (o_step_index),
        .o_running       (o_running),
        .o_finished      (o_finished)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(t_req req, logic [3:0] idx, logic [PctW-1:0] pct,
                             logic [MsW-1:0] ms);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_entry_index <= idx;
        i_entry_pct <= pct;
        i_entry_time_ms <= ms;
        do @(posedge i_clk); while (!o_in_ready);
        if (req == REQ_LOAD) loaded_mask[idx] = 1'b1;
        sb.note_request(req, idx, pct, ms);
    endtask

    // every step the next start would reach must hold a loaded entry
    function automatic bit profile_loaded();
        int unsigned need;
        need = (sb.count_cfg > MaxSteps) ? MaxSteps : sb.count_cfg;
        for (int unsigned i = 0; i < need; i++)
            if (!loaded_mask[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [3:0] first_unloaded();
        for (int unsigned i = 0; i < MaxSteps; i++)
            if (!loaded_mask[i]) return 4'(i);
        return '0;
    endfunction

    task automatic send_random_item();
        int unsigned roll;
        t_req req;
        logic [3:0] idx;
        logic [PctW-1:0] pct;
        logic [MsW-1:0] ms;
        roll = $urandom_range(0, 99);
        idx = 4'($urandom);
        pct = PctW'($urandom);
        ms = MsW'($urandom);
        if (roll < 68) req = REQ_TICK;
        else if (roll < 82) req = REQ_LOAD;
        else if (roll < 92) req = REQ_START;
        else req = REQ_STOP;
        if (req == REQ_LOAD) begin
            pct = ($urandom_range(0, 9) == 0) ? PctW'($urandom_range(1001, 1023))
                                              : PctW'($urandom_range(0, 1000));
            ms = ($urandom_range(0, 6) == 0) ? MsW'($urandom) : MsW'($urandom_range(0, 5));
        end
        if (req == REQ_START && !profile_loaded()) begin
            req = REQ_LOAD;
            idx = first_unloaded();
            pct = PctW'($urandom_range(0, 1000));
            ms = MsW'($urandom_range(0, 5));
        end
        send_item(req, idx, pct, ms);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CfgDataW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        sb.set_config(idx, data);
        @(posedge i_clk);
    endtask

    task automatic apply_config(logic [MsW-1:0] common, logic [RampW-1:0] ramp, logic per,
                                logic [StepCfgW-1:0] count);
        write_reg(CFG_COMMON_STEP, common);
        write_reg(CFG_RAMP, {(CfgDataW-RampW)'($urandom), ramp});
        write_reg(CFG_PER_STEP, {(CfgDataW-1)'($urandom), per});
        write_reg(CFG_STEP_COUNT, {(CfgDataW-StepCfgW)'($urandom), count});
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : receiver
        int unsigned stall;
        t_step_result got;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall = HoldCycles;
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, 4);
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got = {o_target_pct, o_target_valid, o_steady, o_step_index, o_running,
                   o_finished};
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [MsW-1:0] cfg_common;
        logic [RampW-1:0] cfg_ramp;
        logic [StepCfgW-1:0] cfg_count;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: saturation, extremes, restart, load while active, stop, finish
        apply_config(MsW'(2), RampW'(1), 1'b0, StepCfgW'(3));
        send_item(REQ_TICK, 4'd0, '0, '0);
        send_item(REQ_LOAD, 4'd0, PctW'(1023), '0);
        send_item(REQ_LOAD, 4'd1, '0, MsMax);
        send_item(REQ_LOAD, 4'd2, PctMax, MsW'(1));
        send_item(REQ_LOAD, 4'd15, PctW'(10'h2aa), MsW'(24'h555555));
        send_item(REQ_START, 4'd15, PctW'(10'h3ff), MsMax);
        send_item(REQ_TICK, 4'd0, '0, '0);
        send_item(REQ_TICK, 4'd0, '0, '0);
        send_item(REQ_TICK, 4'd0, '0, '0);
        send_item(REQ_START, 4'd0, '0, '0);
        send_item(REQ_TICK, 4'd0, '0, '0);
        send_item(REQ_LOAD, 4'd0, PctW'(5), MsW'(3));
        send_item(REQ_TICK, 4'd0, '0, '0);
        send_item(REQ_STOP, 4'd0, '0, '0);
        send_item(REQ_TICK, 4'd0, '0, '0);
        send_item(REQ_START, 4'd0, '0, '0);
        repeat (7) send_item(REQ_TICK, 4'd0, '0, '0);
        wait_idle();
        apply_config('0, '0, 1'b1, '0);
        send_item(REQ_START, 4'd0, '0, '0);
        send_item(REQ_TICK, 4'd0, '0, '0);
        wait_idle();

        for (int unsigned p = 0; p < NumPhases; p++) begin
            cfg_common = (p == 2) ? MsMax : (p == 5) ? '0 : MsW'($urandom_range(0, 6));
            cfg_ramp = (p == 3) ? RampW'(16'hffff) : (p == 5) ? '0
                                : RampW'($urandom_range(0, 4));
            cfg_count = (p == 0) ? StepCfgW'(16) : (p == 3) ? StepCfgW'(255)
                      : (p == 6) ? StepCfgW'($urandom_range(17, 255))
                      : (p == 7) ? StepCfgW'(1) : StepCfgW'($urandom_range(1, 16));
            apply_config(cfg_common, cfg_ramp, p[0], cfg_count);
            tx_calm = (p == 3);
            rx_calm = (p == 3 || p == 6);
            if (p == 1) begin
                // back pressure: the result side holds off while requests keep coming
                tx_calm = 1'b1;
                rx_hold_req = 1'b1;
                repeat (30) send_random_item();
                tx_calm = 1'b0;
            end
            for (int unsigned n = 0; n < PhaseItems; n++) begin
                if (p == 4 && n == 40) wait_idle();
                send_random_item();
            end
            wait_idle();
        end

        $display("%0d requests over %0d register settings: %0d starts, %0d profiles finished",
                 sb.requests, settings_applied, sb.starts, sb.finishes);
        $display("%0d ticks commanded a throttle target, %0d mismatches",
                 sb.driven_ticks, sb.errors);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
